>>> rtl/psched_pkg.sv
// Package for the priority scheduler: field widths, beat layout and defaults.
// No dependencies; imported by psched_store and priority_schedule_times.

package psched_pkg;

    localparam int MAX_JOBS_DEF = 16;

    localparam int BURST_W = 16;
    localparam int PRIO_W  = 8;
    localparam int JOB_W   = 4;
    localparam int TIME_W  = 20;
    localparam int TOTAL_W = 24;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_FIELD_W = JOB_W + 2 * TIME_W + 2 * TOTAL_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

endpackage

>>> rtl/psched_store.sv
// Job store: burst and priority memories, one write port, one registered read port.
// Depends on psched_pkg.

module psched_store
    import psched_pkg::*;
#(
    parameter int MAX_JOBS = MAX_JOBS_DEF,
    localparam int IDX_W = $clog2(MAX_JOBS)
)
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [IDX_W-1:0]   wr_addr,
    input  logic [BURST_W-1:0] wr_burst,
    input  logic [PRIO_W-1:0]  wr_prio,
    input  logic [IDX_W-1:0]   rd_addr,
    output logic [BURST_W-1:0] rd_burst,
    output logic [PRIO_W-1:0]  rd_prio
);

    logic [BURST_W-1:0] burst_mem [MAX_JOBS];
    logic [PRIO_W-1:0]  prio_mem  [MAX_JOBS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            burst_mem[wr_addr] <= wr_burst;
            prio_mem[wr_addr]  <= wr_prio;
        end
        rd_burst <= burst_mem[rd_addr];
        rd_prio  <= prio_mem[rd_addr];
    end

endmodule

>>> rtl/priority_schedule_times.sv
// Non-preemptive priority scheduler top level: load, selection scan and result emission.
// Depends on psched_pkg and psched_store.

// Jobs load at one beat per cycle until a beat with tlast, or until MAX_JOBS jobs
// are held. The batch is then served in ascending priority, ties in arrival order.
// Each result is found by one scan over all n stored jobs through a single read
// port and one key compare (priority, then index): each job is read in ST_SCAN_RD
// and compared in ST_SCAN_CMP, the result is registered in ST_EMIT and held in
// ST_OUT while m_axis_tready is low. No new job is accepted until the last result
// of the batch is taken.

module priority_schedule_times
    import psched_pkg::*;
#(
    parameter int MAX_JOBS = MAX_JOBS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // burst[15:0], priority_req[23:16]
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // job_index, wait_time, finish_time,
                                                  // total_wait, total_turnaround, pad
    output logic                   m_axis_tlast
);

    localparam int IDX_W = $clog2(MAX_JOBS);
    localparam int CNT_W = $clog2(MAX_JOBS + 1);
    localparam int KEY_W = PRIO_W + IDX_W;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_EMIT,
        ST_OUT
    } state_t;

    state_t                 state_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       num_reg;
    logic [CNT_W-1:0]       emit_reg;
    logic [IDX_W-1:0]       scan_reg;
    logic                   first_reg;
    logic [KEY_W-1:0]       prev_key_reg;
    logic                   best_valid_reg;
    logic [KEY_W-1:0]       best_key_reg;
    logic [BURST_W-1:0]     best_burst_reg;
    logic [TOTAL_W-1:0]     clock_reg;
    logic [TOTAL_W-1:0]     sum_wait_reg;
    logic [TOTAL_W-1:0]     sum_tat_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic                   out_last_reg;

    logic                   load_beat;
    logic                   load_close;
    logic [CNT_W-1:0]       count_inc;
    logic [BURST_W-1:0]     rd_burst;
    logic [PRIO_W-1:0]      rd_prio;
    logic [KEY_W-1:0]       cand_key;
    logic                   cand_take;
    logic                   scan_done;
    logic [TOTAL_W-1:0]     fin_time;
    logic [TOTAL_W-1:0]     sum_wait_new;
    logic [TOTAL_W-1:0]     sum_tat_new;
    logic                   emit_last;
    logic [JOB_W-1:0]       job_out;

    psched_store #(
        .MAX_JOBS (MAX_JOBS)
    ) u_store (
        .clk      (clk),
        .wr_en    (load_beat),
        .wr_addr  (count_reg[IDX_W-1:0]),
        .wr_burst (s_axis_tdata[BURST_W-1:0]),
        .wr_prio  (s_axis_tdata[BURST_W +: PRIO_W]),
        .rd_addr  (scan_reg),
        .rd_burst (rd_burst),
        .rd_prio  (rd_prio)
    );

    assign s_axis_tready = (state_reg == ST_LOAD);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    assign load_beat  = s_axis_tvalid && s_axis_tready;
    assign count_inc  = count_reg + CNT_W'(1);
    assign load_close = s_axis_tlast || (count_inc == CNT_W'(MAX_JOBS));

    // next job: smallest {priority, index} above the previous one
    assign cand_key  = {rd_prio, scan_reg};
    assign cand_take = (first_reg || (cand_key > prev_key_reg))
                       && (!best_valid_reg || (cand_key < best_key_reg));
    assign scan_done = ((CNT_W'(scan_reg) + CNT_W'(1)) == num_reg);

    // time kept at total width so the sums stay exact when the time fields wrap
    assign fin_time     = clock_reg + TOTAL_W'(best_burst_reg);
    assign sum_wait_new = sum_wait_reg + clock_reg;
    assign sum_tat_new  = sum_tat_reg + fin_time;
    assign emit_last    = ((emit_reg + CNT_W'(1)) == num_reg);
    assign job_out      = JOB_W'(best_key_reg[IDX_W-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            count_reg      <= '0;
            num_reg        <= '0;
            emit_reg       <= '0;
            scan_reg       <= '0;
            first_reg      <= 1'b1;
            prev_key_reg   <= '0;
            best_valid_reg <= 1'b0;
            best_key_reg   <= '0;
            best_burst_reg <= '0;
            clock_reg      <= '0;
            sum_wait_reg   <= '0;
            sum_tat_reg    <= '0;
            out_data_reg   <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_LOAD:
                begin
                    if (load_beat)
                    begin
                        if (load_close)
                        begin
                            num_reg        <= count_inc;
                            count_reg      <= '0;
                            emit_reg       <= '0;
                            scan_reg       <= '0;
                            first_reg      <= 1'b1;
                            best_valid_reg <= 1'b0;
                            clock_reg      <= '0;
                            sum_wait_reg   <= '0;
                            sum_tat_reg    <= '0;
                            state_reg      <= ST_SCAN_RD;
                        end
                        else
                        begin
                            count_reg <= count_inc;
                        end
                    end
                end
                ST_SCAN_RD:
                begin
                    state_reg <= ST_SCAN_CMP;
                end
                ST_SCAN_CMP:
                begin
                    if (cand_take)
                    begin
                        best_valid_reg <= 1'b1;
                        best_key_reg   <= cand_key;
                        best_burst_reg <= rd_burst;
                    end
                    if (scan_done)
                    begin
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        scan_reg  <= scan_reg + IDX_W'(1);
                        state_reg <= ST_SCAN_RD;
                    end
                end
                ST_EMIT:
                begin
                    out_data_reg <= OUT_TDATA_W'({
                        emit_last ? sum_tat_new  : TOTAL_W'(0),
                        emit_last ? sum_wait_new : TOTAL_W'(0),
                        fin_time[TIME_W-1:0],
                        clock_reg[TIME_W-1:0],
                        job_out
                    });
                    out_last_reg   <= emit_last;
                    clock_reg      <= fin_time;
                    sum_wait_reg   <= sum_wait_new;
                    sum_tat_reg    <= sum_tat_new;
                    prev_key_reg   <= best_key_reg;
                    first_reg      <= 1'b0;
                    best_valid_reg <= 1'b0;
                    scan_reg       <= '0;
                    emit_reg       <= emit_reg + CNT_W'(1);
                    state_reg      <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (m_axis_tready)
                    begin
                        state_reg <= out_last_reg ? ST_LOAD : ST_SCAN_RD;
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

endmodule

>>> test/priority_schedule_times_test.sv
// Testbench for priority_schedule_times: loads batches of jobs over the input stream and
// checks every schedule result against a scoreboard that sorts each batch on its own.
// Depends on psched_pkg and the priority_schedule_times RTL.

module priority_schedule_times_test;
    import psched_pkg::*;

    localparam int BATCH_MAX    = MAX_JOBS_DEF;
    localparam int JOB_TARGET   = 450;
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 80;

    typedef struct packed {
        logic [JOB_W-1:0]   job;
        logic [TIME_W-1:0]  wait_t;
        logic [TIME_W-1:0]  finish_t;
        logic [TOTAL_W-1:0] tot_wait;
        logic [TOTAL_W-1:0] tot_tat;
        logic               last;
    } sched_result_t;

    typedef enum int {PRIO_ANY, PRIO_NARROW, PRIO_SAME, PRIO_EDGE} prio_mode_t;
    typedef enum int {BURST_ANY, BURST_SHORT, BURST_EDGE, BURST_WIDE} burst_mode_t;

    class sched_scoreboard;
        logic [BURST_W-1:0] burst_q[$];
        logic [PRIO_W-1:0]  prio_q[$];
        sched_result_t      due_q[$];
        int                 errors;

        function new();
            errors = 0;
        endfunction

        // Batch closes on last or when the store is full; then serve lowest priority first,
        // lowest arrival index among equals.
        function void note_job(logic [BURST_W-1:0] burst, logic [PRIO_W-1:0] prio,
                               logic last);
            int                 n;
            int                 pick;
            bit                 taken[BATCH_MAX];
            logic [TIME_W-1:0]  now;
            logic [TOTAL_W-1:0] sum_w;
            logic [TOTAL_W-1:0] sum_t;
            sched_result_t      r;
            burst_q.push_back(burst);
            prio_q.push_back(prio);
            if (!last && burst_q.size() < BATCH_MAX)
                return;
            n     = burst_q.size();
            now   = '0;
            sum_w = '0;
            sum_t = '0;
            foreach (taken[i])
                taken[i] = 1'b0;
            for (int k = 0; k < n; k++)
            begin
                pick = -1;
                for (int j = 0; j < n; j++)
                    if (!taken[j] && (pick < 0 || prio_q[j] < prio_q[pick]))
                        pick = j;
                taken[pick] = 1'b1;
                r          = '0;
                r.job      = pick[JOB_W-1:0];
                r.wait_t   = now;
                now        = now + burst_q[pick];
                r.finish_t = now;
                sum_w      = sum_w + r.wait_t;
                sum_t      = sum_t + r.finish_t;
                r.last     = (k == n - 1);
                if (r.last)
                begin
                    r.tot_wait = sum_w;
                    r.tot_tat  = sum_t;
                end
                due_q.push_back(r);
            end
            burst_q.delete();
            prio_q.delete();
        endfunction

        function void mismatch(string field, longint unsigned want, longint unsigned got);
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            errors++;
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] data, logic last);
            sched_result_t got;
            sched_result_t want;
            got.job      = data[JOB_W-1:0];
            got.wait_t   = data[JOB_W +: TIME_W];
            got.finish_t = data[JOB_W + TIME_W +: TIME_W];
            got.tot_wait = data[JOB_W + 2 * TIME_W +: TOTAL_W];
            got.tot_tat  = data[JOB_W + 2 * TIME_W + TOTAL_W +: TOTAL_W];
            got.last     = last;
            if (due_q.size() == 0)
            begin
                $display("%0t: unexpected result, job_index %0d wait_time %0d finish_time %0d",
                         $time, got.job, got.wait_t, got.finish_t);
                errors++;
                return;
            end
            want = due_q.pop_front();
            if (got.job !== want.job)
                mismatch("job_index", want.job, got.job);
            if (got.wait_t !== want.wait_t)
                mismatch("wait_time", want.wait_t, got.wait_t);
            if (got.finish_t !== want.finish_t)
                mismatch("finish_time", want.finish_t, got.finish_t);
            if (got.tot_wait !== want.tot_wait)
                mismatch("total_wait", want.tot_wait, got.tot_wait);
            if (got.tot_tat !== want.tot_tat)
                mismatch("total_turnaround", want.tot_tat, got.tot_tat);
            if (got.last !== want.last)
                mismatch("last_out", want.last, got.last);
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   s_axis_tlast;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;

    sched_scoreboard    sb = new();
    bit                 calm;
    int                 jobs_sent;
    int                 idle_cycles;
    int                 ready_hold;
    logic [BURST_W-1:0] bur_v[BATCH_MAX];
    logic [PRIO_W-1:0]  pri_v[BATCH_MAX];

    priority_schedule_times #(
        .MAX_JOBS (BATCH_MAX)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // mostly no gap or a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_job(input logic [BURST_W-1:0] burst, input logic [PRIO_W-1:0] prio,
                            input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {prio, burst};
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_job(burst, prio, last);
        jobs_sent++;
    endtask

    task automatic send_batch(input int n, input bit use_last);
        calm = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < n; i++)
            send_job(bur_v[i], pri_v[i], (i == n - 1) ? use_last : 1'b0);
    endtask

    task automatic fill_random(input int n);
        prio_mode_t  pm;
        burst_mode_t bm;
        logic [PRIO_W-1:0] same_p;
        pm     = prio_mode_t'($urandom_range(0, 3));
        bm     = burst_mode_t'($urandom_range(0, 3));
        same_p = PRIO_W'($urandom_range(0, 255));
        for (int i = 0; i < n; i++)
        begin
            case (pm)
                PRIO_NARROW: pri_v[i] = PRIO_W'($urandom_range(0, 3));
                PRIO_SAME:   pri_v[i] = same_p;
                PRIO_EDGE:   pri_v[i] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                default:     pri_v[i] = PRIO_W'($urandom_range(0, 255));
            endcase
            case (bm)
                BURST_SHORT: bur_v[i] = BURST_W'($urandom_range(0, 15));
                BURST_EDGE:  bur_v[i] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                default:     bur_v[i] = BURST_W'($urandom_range(0, 65535));
            endcase
        end
    endtask

    // result side: random backpressure, checked at each accepted beat
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tlast);
        if (ready_hold > 0)
            ready_hold = ready_hold - 1;
        else if (calm || $urandom_range(0, 2) != 0)
        begin
            m_axis_tready <= 1'b1;
            ready_hold = $urandom_range(0, 8);
        end
        else
        begin
            m_axis_tready <= 1'b0;
            ready_hold = pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("** priority_schedule_times: FAILED **");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int  n;
        int  r;
        bit  use_last;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        calm          = 1'b0;
        jobs_sent     = 0;
        idle_cycles   = 0;
        ready_hold    = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single jobs at the field extremes
        bur_v[0] = 16'h0000;
        pri_v[0] = 8'h00;
        send_batch(1, 1'b1);
        bur_v[0] = 16'hFFFF;
        pri_v[0] = 8'hFF;
        send_batch(1, 1'b1);

        // reorder with ties
        bur_v[0] = 16'd10;
        bur_v[1] = 16'd20;
        bur_v[2] = 16'd30;
        bur_v[3] = 16'd40;
        pri_v[0] = 8'd9;
        pri_v[1] = 8'd2;
        pri_v[2] = 8'd9;
        pri_v[3] = 8'd2;
        send_batch(4, 1'b1);

        // full store without tlast, largest bursts give the largest totals
        for (int i = 0; i < BATCH_MAX; i++)
        begin
            bur_v[i] = 16'hFFFF;
            pri_v[i] = (i % 2) ? 8'h00 : 8'hFF;
        end
        send_batch(BATCH_MAX, 1'b0);

        while (jobs_sent < JOB_TARGET)
        begin
            r = $urandom_range(0, 9);
            if (r < 7)
                n = $urandom_range(1, 8);
            else if (r < 9)
                n = $urandom_range(9, BATCH_MAX - 1);
            else
                n = BATCH_MAX;
            use_last = (n == BATCH_MAX) ? 1'($urandom_range(0, 1)) : 1'b1;
            fill_random(n);
            send_batch(n, use_last);
        end
        s_axis_tvalid <= 1'b0;
        calm = 1'b0;

        while (sb.due_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("** priority_schedule_times: PASSED **");
        else
            $display("** priority_schedule_times: FAILED **");
        $finish;
    end

endmodule
